>>> hw/rtl/olis_pkg.sv
// Shared types and codes for the ordered list block.
// No dependencies; every other file imports this package.
`default_nettype none

package olis_pkg;

  localparam int VALUE_W     = 32;
  localparam int CMD_W       = 3;
  localparam int POS_W       = 7;
  localparam int STATUS_W    = 3;
  localparam int INDEX_W     = 6;
  localparam int MAX_RESULTS = 64;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    value_t   value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DUMP
  } olis_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/olis_req_if.sv
// Command channel: valid/ready handshake with command, value and position.
// Depends on olis_pkg.
`default_nettype none

interface olis_req_if
  import olis_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  value_t             value;
  logic [POS_W-1:0]   position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/olis_rsp_if.sv
// Result channel: valid/ready handshake with status, index, entry value, last.
// Depends on olis_pkg.
`default_nettype none

interface olis_rsp_if
  import olis_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  index;
  value_t              entry_value;
  logic                last;

  modport source (output valid, status, index, entry_value, last, input ready);
  modport sink   (input valid, status, index, entry_value, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ordered_list_insert_search.sv
// Ordered list of signed 32-bit values held in a chain of DEPTH cells.
// Depends on olis_pkg, olis_req_if, olis_rsp_if and olis_cell.
//
// Push front, push back and insert update the chain in parallel: every cell
// shifts or loads and the single result is registered at once. Search and
// dump rotate the occupied part of the chain through cell 0, one entry per
// cycle unless a dump is held by a result stall, and restore the original
// order after entry_count steps. A command is taken only while no search or
// dump runs and the result register is free or being emptied. Commands 5 to
// 7 are taken and dropped without a result.
`default_nettype none

module ordered_list_insert_search
  import olis_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  olis_req_if.sink   req,
  olis_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int SW = (CW > INDEX_W) ? CW : INDEX_W;

  olis_state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] step, step_next;
  value_t key, key_next;
  logic found, found_next;
  logic [INDEX_W-1:0] found_idx, found_idx_next;

  logic ovalid, ovalid_next;
  logic [STATUS_W-1:0] ostatus, ostatus_next;
  logic [INDEX_W-1:0] oindex, oindex_next;
  value_t ovalue, ovalue_next;
  logic olast, olast_next;

  cell_ctl_t ctl;
  logic [PW-1:0] ins_pos;

  value_t cell_data [DEPTH];

  logic [PW-1:0] cnt_l;
  logic [PW-1:0] step_l;
  logic [PW-1:0] n_emit;
  logic [SW-1:0] step_w;
  logic [INDEX_W-1:0] step_idx;
  logic slot_free;
  logic accept;
  logic step_last;
  logic emitting;
  logic hit;

  assign cnt_l    = PW'(cnt);
  assign step_l   = PW'(step);
  assign n_emit   = (cnt_l < PW'(MAX_RESULTS)) ? cnt_l : PW'(MAX_RESULTS);
  assign step_w   = SW'(step);
  assign step_idx = step_w[INDEX_W-1:0];
  assign slot_free = !ovalid || rsp.ready;
  assign step_last = (step_l + PW'(1)) == cnt_l;
  assign emitting  = step_l < n_emit;
  assign hit       = cell_data[0] == key;

  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = ovalid;
  assign rsp.status      = ostatus;
  assign rsp.index       = oindex;
  assign rsp.entry_value = ovalue;
  assign rsp.last        = olast;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t prev_d;
    value_t next_d;

    assign prev_d = (i == 0) ? ctl.value : cell_data[(i == 0) ? 0 : i - 1];
    assign next_d = cell_data[(i == DEPTH - 1) ? 0 : i + 1];

    olis_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .at_pos    (ins_pos == PW'(i)),
      .after_pos ((PW'(i) > ins_pos) && (PW'(i) <= cnt_l)),
      .is_tail   (PW'(i + 1) == cnt_l),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (cell_data[0]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    step_next      = step;
    key_next       = key;
    found_next     = found;
    found_idx_next = found_idx;
    ovalid_next    = ovalid && !rsp.ready;
    ostatus_next   = ostatus;
    oindex_next    = oindex;
    ovalue_next    = ovalue;
    olast_next     = olast;
    ctl.op         = CELL_HOLD;
    ctl.value      = req.value;
    ins_pos        = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              if (req.cmd == CMD_PUSH_BACK) begin
                ins_pos = cnt_l;
              end else if (req.cmd == CMD_INSERT) begin
                ins_pos = PW'(req.position);
              end
              ovalid_next = 1'b1;
              oindex_next = '0;
              ovalue_next = '0;
              olast_next  = 1'b1;
              if (cnt_l == PW'(DEPTH)) begin
                ostatus_next = ST_FULL;
              end else if (ins_pos > cnt_l) begin
                ostatus_next = ST_BADPOS;
              end else begin
                ostatus_next = ST_OK;
                ctl.op       = CELL_INSERT;
                cnt_next     = cnt + CW'(1);
              end
            end
            CMD_SEARCH: begin
              if (cnt == '0) begin
                ovalid_next  = 1'b1;
                ostatus_next = ST_NOTFOUND;
                oindex_next  = '0;
                ovalue_next  = '0;
                olast_next   = 1'b1;
              end else begin
                state_next = S_SEARCH;
                key_next   = req.value;
                found_next = 1'b0;
                step_next  = '0;
              end
            end
            CMD_DUMP: begin
              if (cnt == '0) begin
                ovalid_next  = 1'b1;
                ostatus_next = ST_EMPTY;
                oindex_next  = '0;
                ovalue_next  = '0;
                olast_next   = 1'b1;
              end else begin
                state_next = S_DUMP;
                step_next  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        ctl.op    = CELL_ROTATE;
        step_next = step + CW'(1);
        if (!found && hit) begin
          found_next     = 1'b1;
          found_idx_next = step_idx;
        end
        if (step_last) begin
          // result slot was freed when the search was taken
          state_next   = S_IDLE;
          ovalid_next  = 1'b1;
          ostatus_next = (found || hit) ? ST_OK : ST_NOTFOUND;
          oindex_next  = found ? found_idx : (hit ? step_idx : '0);
          ovalue_next  = '0;
          olast_next   = 1'b1;
        end
      end
      S_DUMP: begin
        // hold the chain while the result side stalls an emitted entry
        if (!emitting || slot_free) begin
          ctl.op    = CELL_ROTATE;
          step_next = step + CW'(1);
          if (emitting) begin
            ovalid_next  = 1'b1;
            ostatus_next = ST_OK;
            oindex_next  = step_idx;
            ovalue_next  = cell_data[0];
            olast_next   = (step_l + PW'(1)) == n_emit;
          end
          if (step_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      step   <= '0;
      found  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      step   <= step_next;
      found  <= found_next;
      ovalid <= ovalid_next;
    end
    key       <= key_next;
    found_idx <= found_idx_next;
    ostatus   <= ostatus_next;
    oindex    <= oindex_next;
    ovalue    <= ovalue_next;
    olast     <= olast_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/olis_cell.sv
// One list cell: holds one entry, takes its left neighbor on an insert
// shift and its right neighbor (or the head, at the tail) on a rotate.
// Depends on olis_pkg.
`default_nettype none

module olis_cell
  import olis_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      at_pos,
  input  wire logic      after_pos,
  input  wire logic      is_tail,
  input  wire value_t    prev_data,
  input  wire value_t    next_data,
  input  wire value_t    head_data,
  output      value_t    data
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (at_pos) begin
          data <= ctl.value;
        end else if (after_pos) begin
          data <= prev_data;
        end
      end
      CELL_ROTATE: begin
        data <= is_tail ? head_data : next_data;
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for ordered_list_insert_search: random and directed list
// commands with idle gaps on both channels. Depends on olis_pkg and both olis_*_if.

module tb;
  import olis_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    value_t           value;
    logic [POS_W-1:0] position;
  } list_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    value_t              entry_value;
    logic                last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  olis_req_if cmd_ch ();
  olis_rsp_if res_ch ();

  ordered_list_insert_search #(.DEPTH(LIST_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req(cmd_ch),
    .rsp(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the list contents, advanced as each command item is accepted.
  value_t       list_model [LIST_DEPTH];
  int           model_count = 0;
  list_result_t expected_results[$];

  list_cmd_t    pending_cmds[$];
  list_cmd_t    cur_cmd;
  int           send_gap = 0;
  int           stall_left = 0;
  int           quiet_left = 0;
  int           fail_count = 0;

  // Generation-side view: how full the list will be and which values it holds.
  int           gen_count = 0;
  value_t       gen_pool[$];

  task automatic predict_list_op(input list_cmd_t c);
    list_result_t r;
    int slot;
    int hit;
    int n;
    r = '{status: ST_OK, index: '0, entry_value: '0, last: 1'b1};
    case (c.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        slot = (c.cmd == CMD_PUSH_FRONT) ? 0 :
               (c.cmd == CMD_PUSH_BACK) ? model_count : int'(c.position);
        // Full takes priority over a bad position.
        if (model_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (slot > model_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = model_count; i > slot; i--) list_model[i] = list_model[i-1];
          list_model[slot] = c.value;
          model_count++;
        end
        expected_results.insert(expected_results.size(), r);
      end
      CMD_SEARCH: begin
        hit = -1;
        for (int i = 0; i < model_count; i++)
          if (hit < 0 && list_model[i] == c.value) hit = i;
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.index = INDEX_W'(hit);
        expected_results.insert(expected_results.size(), r);
      end
      CMD_DUMP: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
          expected_results.insert(expected_results.size(), r);
        end else begin
          n = (model_count > MAX_RESULTS) ? MAX_RESULTS : model_count;
          for (int i = 0; i < n; i++) begin
            r.index       = INDEX_W'(i);
            r.entry_value = list_model[i];
            r.last        = (i == n - 1);
            expected_results.insert(expected_results.size(), r);
          end
        end
      end
      default: ;  // unused codes are dropped without a result
    endcase
  endtask

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, value_t value,
                                    logic [POS_W-1:0] position);
    pending_cmds.insert(pending_cmds.size(), '{cmd: cmd, value: value, position: position});
    if ((cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK || cmd == CMD_INSERT) &&
        gen_count < LIST_DEPTH && (cmd != CMD_INSERT || position <= gen_count)) begin
      gen_count++;
      gen_pool.insert(gen_pool.size(), value);
    end
  endfunction

  // Mostly short gaps, a few long ones, none during a quiet stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_left != 0 || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (quiet_left > 0) quiet_left <= quiet_left - 1;
    else if ($urandom_range(0, 199) == 0) quiet_left <= $urandom_range(50, 200);
  end

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) predict_list_op(cur_cmd);
      // Hold the item while the block is not ready.
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_gap > 0) begin
          cmd_ch.valid <= 1'b0;
          send_gap--;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds[0];
          pending_cmds.delete(0);
          cmd_ch.cmd      <= cur_cmd.cmd;
          cmd_ch.value    <= cur_cmd.value;
          cmd_ch.position <= cur_cmd.position;
          cmd_ch.valid    <= 1'b1;
          send_gap = pick_gap();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d index %0d entry_value %0d last %0d",
                 res_ch.status, res_ch.index, res_ch.entry_value, res_ch.last);
          fail_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            fail_count++;
          end
          if (res_ch.index !== want.index) begin
            $error("index: expected %0d, actual %0d", want.index, res_ch.index);
            fail_count++;
          end
          if (res_ch.entry_value !== want.entry_value) begin
            $error("entry_value: expected %0d, actual %0d",
                   want.entry_value, res_ch.entry_value);
            fail_count++;
          end
          if (res_ch.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, res_ch.last);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  initial begin
    int roll;
    int kind;
    logic [CMD_W-1:0] c;
    logic [POS_W-1:0] p;
    value_t v;

    cmd_ch.valid    = 1'b0;
    cmd_ch.cmd      = CMD_PUSH_FRONT;
    cmd_ch.value    = '0;
    cmd_ch.position = '0;
    res_ch.ready    = 1'b0;

    // Directed: empty list, bad positions, extremes, append at tail, duplicates.
    queue_cmd(CMD_DUMP, '0, '0);
    queue_cmd(CMD_SEARCH, '0, '0);
    queue_cmd(CMD_INSERT, 32'sh1234, 7'd1);
    queue_cmd(CMD_INSERT, 32'sh7fffffff, 7'd0);
    queue_cmd(CMD_PUSH_BACK, 32'sh80000000, 7'd127);
    queue_cmd(CMD_INSERT, -32'sd1, 7'd2);
    queue_cmd(CMD_PUSH_FRONT, '0, '0);
    queue_cmd(CMD_INSERT, 32'sd5, 7'd1);
    queue_cmd(CMD_INSERT, 32'sd9, 7'd127);
    queue_cmd(CMD_INSERT, 32'sd9, 7'd6);
    queue_cmd(CMD_SEARCH, 32'sh80000000, '0);
    queue_cmd(CMD_SEARCH, -32'sd1, '0);
    queue_cmd(CMD_SEARCH, 32'sh7fffffff, '0);
    queue_cmd(CMD_SEARCH, 32'sd12345, '0);
    queue_cmd(CMD_PUSH_BACK, 32'sd5, '0);
    queue_cmd(CMD_SEARCH, 32'sd5, '0);
    for (int k = CMD_UNUSED_LO; k <= CMD_UNUSED_HI; k++)
      queue_cmd(CMD_W'(k), value_t'($urandom), POS_W'($urandom));
    queue_cmd(CMD_DUMP, '0, '0);

    // Random: the list grows until full partway through, searches mostly hit.
    for (int n = 0; n < 500; n++) begin
      roll = $urandom_range(0, 99);
      p = POS_W'($urandom_range(0, 127));
      v = value_t'($urandom);
      if (roll < 22) begin
        kind = $urandom_range(0, 2);
        c = (kind == 0) ? CMD_PUSH_FRONT : (kind == 1) ? CMD_PUSH_BACK : CMD_INSERT;
        kind = $urandom_range(0, 9);
        if (kind >= 6 && kind < 8 && gen_pool.size() != 0)
          v = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
        else if (kind >= 8)
          case ($urandom_range(0, 3))
            0: v = 32'sh80000000;
            1: v = 32'sh7fffffff;
            2: v = '0;
            default: v = -32'sd1;
          endcase
        if (c == CMD_INSERT) begin
          if ($urandom_range(0, 4) != 0) p = POS_W'($urandom_range(0, gen_count));
          else p = POS_W'($urandom_range(gen_count + 1, 127));
        end
      end else if (roll < 80) begin
        c = CMD_SEARCH;
        if ($urandom_range(0, 99) < 65 && gen_pool.size() != 0)
          v = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
      end else if (roll < 94) begin
        c = CMD_DUMP;
      end else begin
        c = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      queue_cmd(c, v, p);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // Allow a trailing search or dump to show any stray result.
    repeat (2 * LIST_DEPTH + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> ordered_list_insert_search.f
hw/rtl/olis_pkg.sv
hw/rtl/olis_req_if.sv
hw/rtl/olis_rsp_if.sv
hw/rtl/olis_cell.sv
hw/rtl/ordered_list_insert_search.sv
test/tb.sv
